>>> rtl/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

   localparam int ANGLE_W     = 32;
   localparam int OUT_W       = 16;
   localparam int FRAC_BITS   = 28;
   localparam int X_W         = 30;
   localparam int TERM_W      = 31;
   localparam int PROD_W      = 33;
   localparam int ACC_W       = 35;
   localparam int RECIP_SHIFT = 34;
   localparam int MAG_W       = 24;

   localparam logic [17:0] TURN_OFFSET  = 18'd33120;
   localparam logic [31:0] TURN_RECIP   = 32'd46604;
   localparam int          TURN_SHIFT   = 24;
   localparam logic [16:0] DEG_TURN     = 17'd360;
   localparam logic [8:0]  DEG_HALF     = 9'd180;
   localparam logic [50:0] DEG_TO_RAD   = 51'd74961321;
   localparam int          RAD_SHIFT    = 20;

   localparam logic signed [ACC_W-1:0] ONE_Q28 = ACC_W'(64'd1 << FRAC_BITS);

   typedef struct packed {
      logic                     valid;
      logic                     neg;
      logic [X_W-1:0]           x;
      logic [TERM_W-1:0]        term;
      logic signed [ACC_W-1:0]  sin_acc;
      logic signed [ACC_W-1:0]  cos_acc;
   } tsc_lane_type;

endpackage

`default_nettype wire

>>> rtl/tsc_reduce.sv
`default_nettype none

module tsc_reduce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
   output tsc_pkg::tsc_lane_type             lane_out
);
   import tsc_pkg::*;

   logic [17:0]        turn_sum;
   logic [16:0]        turn_u;
   logic [31:0]        turn_prod;
   logic               valid_a_ff;
   logic [16:0]        u_a_ff;
   logic [7:0]         q_a_ff;
   logic [15:0]        frac_a_ff;

   logic [16:0]        rem_wide;
   logic [8:0]         rem;
   logic               neg_b_in;
   logic [24:0]        mag_wide;
   logic [MAG_W-1:0]   mag_b_in;
   logic               valid_b_ff;
   logic               neg_b_ff;
   logic [MAG_W-1:0]   mag_b_ff;

   logic [50:0]        rad_sum;
   tsc_lane_type       lane_in;
   tsc_lane_type       lane_ff;

   assign turn_sum  = {{2{in_angle[ANGLE_W-1]}}, in_angle[ANGLE_W-1:16]} + TURN_OFFSET;
   assign turn_u    = turn_sum[16:0];
   assign turn_prod = 32'(turn_u) * TURN_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      u_a_ff    <= turn_u;
      q_a_ff    <= turn_prod[TURN_SHIFT +: 8];
      frac_a_ff <= in_angle[15:0];
   end

   assign rem_wide = u_a_ff - 17'(17'(q_a_ff) * DEG_TURN);
   assign rem      = rem_wide[8:0];
   assign neg_b_in = rem >= DEG_HALF;
   assign mag_wide = {(DEG_TURN[8:0] - rem), 16'h0000} - 25'(frac_a_ff);

   always_comb begin
      if (neg_b_in) begin
         mag_b_in = mag_wide[MAG_W-1:0];
      end else begin
         mag_b_in = {rem[7:0], frac_a_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      neg_b_ff <= neg_b_in;
      mag_b_ff <= mag_b_in;
   end

   assign rad_sum = 51'(mag_b_ff) * DEG_TO_RAD + (51'd1 << (RAD_SHIFT - 1));

   always_comb begin
      lane_in.valid   = valid_b_ff;
      lane_in.neg     = neg_b_ff;
      lane_in.x       = rad_sum[RAD_SHIFT +: X_W];
      lane_in.term    = TERM_W'(rad_sum[RAD_SHIFT +: X_W]);
      lane_in.sin_acc = $signed(ACC_W'(rad_sum[RAD_SHIFT +: X_W]));
      lane_in.cos_acc = ONE_Q28;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

>>> rtl/tsc_cell.sv
`default_nettype none

module tsc_cell #(
   parameter int K = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsc_pkg::tsc_lane_type lane_in,
   output tsc_pkg::tsc_lane_type lane_out
);
   import tsc_pkg::*;

   localparam int                      MUL_W    = TERM_W + X_W;
   localparam int                      QMUL_W   = PROD_W + RECIP_SHIFT;
   localparam logic [PROD_W-1:0]       HALF_K   = PROD_W'(K / 2);
   localparam logic [RECIP_SHIFT-1:0]  RECIP    = RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / K);
   localparam logic [PROD_W:0]         K_WIDE   = (PROD_W + 1)'(K);
   localparam bit                      IS_SINE  = (K % 2) == 1;
   localparam bit                      MINUS    = ((K / 2) % 2) == 1;

   logic [MUL_W-1:0]   prod;
   logic [MUL_W-1:0]   prod_rnd;
   logic [PROD_W-1:0]  p1_ff;
   tsc_lane_type       lane1_ff;

   logic [PROD_W-1:0]  num;
   logic [QMUL_W-1:0]  qprod;
   logic [PROD_W-1:0]  n2_ff;
   logic [PROD_W-2:0]  qe2_ff;
   tsc_lane_type       lane2_ff;

   logic [PROD_W:0]    qk;
   logic [PROD_W:0]    rem;
   logic [PROD_W-2:0]  quot;
   logic [TERM_W-1:0]  term3_ff;
   tsc_lane_type       lane3_ff;

   logic signed [ACC_W-1:0] term_ext;
   tsc_lane_type       lane4_in;
   tsc_lane_type       lane4_ff;

   assign prod     = MUL_W'(lane_in.term) * MUL_W'(lane_in.x);
   assign prod_rnd = prod + (MUL_W'(1) << (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         lane1_ff.valid <= 1'b0;
      end else begin
         lane1_ff <= lane_in;
      end
      p1_ff <= prod_rnd[FRAC_BITS +: PROD_W];
   end

   assign num   = p1_ff + HALF_K;
   assign qprod = QMUL_W'(num) * QMUL_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane2_ff.valid <= 1'b0;
      end else begin
         lane2_ff <= lane1_ff;
      end
      n2_ff  <= num;
      qe2_ff <= qprod[RECIP_SHIFT +: PROD_W - 1];
   end

   assign qk   = (PROD_W + 1)'(qe2_ff) * K_WIDE;
   assign rem  = (PROD_W + 1)'(n2_ff) - qk;
   assign quot = qe2_ff + (PROD_W - 1)'(rem >= K_WIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane3_ff.valid <= 1'b0;
      end else begin
         lane3_ff <= lane2_ff;
      end
      term3_ff <= quot[TERM_W-1:0];
   end

   assign term_ext = $signed(ACC_W'(term3_ff));

   always_comb begin
      lane4_in      = lane3_ff;
      lane4_in.term = term3_ff;
      if (IS_SINE) begin
         if (MINUS) begin
            lane4_in.sin_acc = lane3_ff.sin_acc - term_ext;
         end else begin
            lane4_in.sin_acc = lane3_ff.sin_acc + term_ext;
         end
      end else begin
         if (MINUS) begin
            lane4_in.cos_acc = lane3_ff.cos_acc - term_ext;
         end else begin
            lane4_in.cos_acc = lane3_ff.cos_acc + term_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane4_ff.valid <= 1'b0;
      end else begin
         lane4_ff <= lane4_in;
      end
   end

   assign lane_out = lane4_ff;

endmodule

`default_nettype wire

>>> rtl/tsc_round.sv
`default_nettype none

module tsc_round (
   input  logic                              clock,
   input  logic                              reset,
   input  tsc_pkg::tsc_lane_type             lane_in,
   output logic                              out_valid,
   output logic signed [tsc_pkg::OUT_W-1:0]  out_sine,
   output logic signed [tsc_pkg::OUT_W-1:0]  out_cosine
);
   import tsc_pkg::*;

   localparam int RND_W = ACC_W - 13;

   logic               valid1_ff;
   logic [ACC_W-1:0]   sin_mag_ff;
   logic               sin_sign_ff;
   logic [ACC_W-1:0]   cos_mag_ff;
   logic               cos_sign_ff;

   logic               valid2_ff;
   logic signed [OUT_W-1:0] sine2_ff;
   logic signed [OUT_W-1:0] cosine2_ff;

   function automatic logic signed [OUT_W-1:0] sat_q14(input logic [ACC_W-1:0] mag,
                                                       input logic sign);
      logic [ACC_W:0]     sum;
      logic [RND_W-1:0]   r;
      logic [OUT_W-1:0]   res;
      sum = (ACC_W + 1)'(mag) + (ACC_W + 1)'(8192);
      r   = sum[ACC_W:14];
      if (!sign) begin
         res = (r > RND_W'(32767)) ? 16'h7FFF : r[OUT_W-1:0];
      end else begin
         res = (r > RND_W'(32768)) ? 16'h8000 : (16'h0000 - r[OUT_W-1:0]);
      end
      return $signed(res);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= lane_in.valid;
      end
      sin_mag_ff  <= lane_in.sin_acc[ACC_W-1] ? $unsigned(-lane_in.sin_acc)
                                              : $unsigned(lane_in.sin_acc);
      sin_sign_ff <= lane_in.sin_acc[ACC_W-1] ^ lane_in.neg;
      cos_mag_ff  <= lane_in.cos_acc[ACC_W-1] ? $unsigned(-lane_in.cos_acc)
                                              : $unsigned(lane_in.cos_acc);
      cos_sign_ff <= lane_in.cos_acc[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      sine2_ff   <= sat_q14(sin_mag_ff, sin_sign_ff);
      cosine2_ff <= sat_q14(cos_mag_ff, cos_sign_ff);
   end

   assign out_valid  = valid2_ff;
   assign out_sine   = sine2_ff;
   assign out_cosine = cosine2_ff;

endmodule

`default_nettype wire

>>> rtl/taylor_sine_cosine_top.sv
`default_nettype none

// Computes the sine and cosine of an angle given in signed Q16.16 degrees as Taylor sums up
// to HIGHEST_POWER, returning both in signed Q2.14, rounded and saturated. An item is taken
// in every cycle that start is high, since busy is always low. Each item's result shows on
// the rsp_ ports for one cycle with rsp_strobe high, in the order the items came in.
// Each item passes through angle reduction and conversion to radians, then through each of
// the HIGHEST_POWER-1 term cells in the chain, and then through rounding. The receiver
// cannot stall, so every result must be captured in the cycle it appears. Reset drops every
// item still in flight.

module taylor_sine_cosine_top #(
   parameter int HIGHEST_POWER = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [tsc_pkg::ANGLE_W-1:0]    req_angle_degrees,
   output logic                                  rsp_strobe,
   output logic signed [tsc_pkg::OUT_W-1:0]      rsp_sine_value,
   output logic signed [tsc_pkg::OUT_W-1:0]      rsp_cosine_value
);
   import tsc_pkg::*;

   localparam int CELLS = HIGHEST_POWER - 1;

   tsc_lane_type lane [CELLS + 1];

   assign busy = 1'b0;

   tsc_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_angle (req_angle_degrees),
      .lane_out (lane[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tsc_cell #(
         .K (i + 2)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lane[i]),
         .lane_out (lane[i + 1])
      );
   end

   tsc_round u_round (
      .clock      (clock),
      .reset      (reset),
      .lane_in    (lane[CELLS]),
      .out_valid  (rsp_strobe),
      .out_sine   (rsp_sine_value),
      .out_cosine (rsp_cosine_value)
   );

endmodule

`default_nettype wire

>>> rtl/tsc_checker.sv
`default_nettype none

module tsc_checker #(
   parameter int HIGHEST_POWER = 10
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic signed [tsc_pkg::ANGLE_W-1:0]    req_angle_degrees,
   input logic                                  rsp_strobe,
   input logic signed [tsc_pkg::OUT_W-1:0]      rsp_sine_value,
   input logic signed [tsc_pkg::OUT_W-1:0]      rsp_cosine_value
);

   localparam int LATENCY = 4 * HIGHEST_POWER + 1;

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy was raised");

   a_item_returns: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_strobe)
      else $error("an accepted item produced no result at the expected cycle");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("a result appeared without a matching item");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (start && req_angle_degrees == 0) |->
         ##LATENCY (rsp_sine_value == 16'sd0 && rsp_cosine_value == 16'sd16384))
      else $error("zero angle did not give sine 0 and cosine 1");

endmodule

bind taylor_sine_cosine_top tsc_checker #(
   .HIGHEST_POWER (HIGHEST_POWER)
) u_tsc_checker (.*);

`default_nettype wire

>>> tb/taylor_sine_cosine_top_test.sv
`default_nettype none

module taylor_sine_cosine_top_test;
   import tsc_pkg::*;

   localparam int HIGHEST_POWER = 10;
   localparam int LATENCY = 4 * HIGHEST_POWER + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam longint TURN_Q16 = 64'sd23592960;
   localparam longint HALF_TURN_Q16 = 64'sd11796480;
   localparam longint QUARTER_TURN_Q16 = 64'sd5898240;
   localparam int ITEMS_PER_PHASE = 200;

   typedef struct {
      logic signed [OUT_W-1:0] sine;
      logic signed [OUT_W-1:0] cosine;
   } trig_pair_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [ANGLE_W-1:0] req_angle_degrees;
   logic rsp_strobe;
   logic signed [OUT_W-1:0] rsp_sine_value;
   logic signed [OUT_W-1:0] rsp_cosine_value;

   trig_pair_type expected_pairs[$];
   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;

   taylor_sine_cosine_top #(
      .HIGHEST_POWER(HIGHEST_POWER)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_angle_degrees(req_angle_degrees),
      .rsp_strobe(rsp_strobe),
      .rsp_sine_value(rsp_sine_value),
      .rsp_cosine_value(rsp_cosine_value)
   );

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [OUT_W-1:0] q28_to_output(input longint acc);
      longint rounded;
      if (acc >= 0) begin
         rounded = (acc + 8192) >>> 14;
      end else begin
         rounded = -((-acc + 8192) >>> 14);
      end
      if (rounded > 32767) begin
         rounded = 32767;
      end
      if (rounded < -32768) begin
         rounded = -32768;
      end
      return rounded[OUT_W-1:0];
   endfunction

   function automatic trig_pair_type predict_sine_cosine(input logic signed [ANGLE_W-1:0] angle);
      trig_pair_type pair;
      longint reduced;
      logic negative;
      longint unsigned magnitude;
      longint unsigned radians;
      longint unsigned term;
      longint unsigned divisor;
      longint sine_sum;
      longint cosine_sum;
      reduced = longint'(angle) % TURN_Q16;
      if (reduced < 0) begin
         reduced = reduced + TURN_Q16;
      end
      if (reduced >= HALF_TURN_Q16) begin
         reduced = reduced - TURN_Q16;
      end
      negative = reduced < 0;
      magnitude = negative ? longint'(-reduced) : longint'(reduced);
      radians = (magnitude * 64'(DEG_TO_RAD) + (64'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT;
      term = radians;
      sine_sum = longint'(radians);
      cosine_sum = longint'(64'd1 << FRAC_BITS);
      for (int k = 2; k <= HIGHEST_POWER; k++) begin
         divisor = longint'(k);
         term = (term * radians + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         term = (term + divisor / 2) / divisor;
         if (k % 2 == 1) begin
            if (((k - 1) / 2) % 2 == 1) begin
               sine_sum = sine_sum - longint'(term);
            end else begin
               sine_sum = sine_sum + longint'(term);
            end
         end else begin
            if ((k / 2) % 2 == 1) begin
               cosine_sum = cosine_sum - longint'(term);
            end else begin
               cosine_sum = cosine_sum + longint'(term);
            end
         end
      end
      if (negative) begin
         sine_sum = -sine_sum;
      end
      pair.sine = q28_to_output(sine_sum);
      pair.cosine = q28_to_output(cosine_sum);
      return pair;
   endfunction

   always @(posedge clock) begin
      trig_pair_type want;
      if (!reset && rsp_strobe) begin
         if (expected_pairs.size() == 0) begin
            $error("result with no item pending: sine %0d cosine %0d",
               rsp_sine_value, rsp_cosine_value);
            error_count++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_sine_value !== want.sine) begin
               $error("sine_value: expected %0d, actual %0d", want.sine, rsp_sine_value);
               error_count++;
            end
            if (rsp_cosine_value !== want.cosine) begin
               $error("cosine_value: expected %0d, actual %0d", want.cosine, rsp_cosine_value);
               error_count++;
            end
         end
      end
   end

   task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
      int gap;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 4);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_angle_degrees <= angle;
      do begin
         @(posedge clock);
      end while (busy);
      expected_pairs.push_back(predict_sine_cosine(angle));
   endtask

   task automatic wait_for_results;
      int waited;
      start <= 1'b0;
      waited = 0;
      while (expected_pairs.size() != 0 && waited < LATENCY + 20) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pairs.size() != 0) begin
         $error("%0d expected results never arrived", expected_pairs.size());
         error_count++;
         expected_pairs.delete();
      end
   endtask

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      longint value;
      case ($urandom_range(3))
         0: value = longint'($signed($urandom()));
         1: value = (longint'($urandom_range(1440)) - 720) * 65536 + $urandom_range(65535);
         2: value = (longint'($urandom_range(16)) - 8) * QUARTER_TURN_Q16
               + longint'($urandom_range(8)) - 4;
         default: value = longint'($urandom_range(23592959)) - HALF_TURN_Q16;
      endcase
      return value[ANGLE_W-1:0];
   endfunction

   task automatic test_directed_angles;
      logic signed [ANGLE_W-1:0] angles[$];
      sender_idle_pct = 0;
      angles = '{32'sd0, 32'sd1, -32'sd1, 32'sd5898240, -32'sd5898240, 32'sd11796480,
         -32'sd11796480, 32'sd11796479, 32'sd11796481, -32'sd11796481, 32'sd23592960,
         32'sd17694720, 32'sd2949120, 32'sd1966080, 32'sd3932160, 32'sd7864320,
         32'sd9830400, 32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
         32'sd2123366400, -32'sd2123366400};
      foreach (angles[i]) begin
         send_angle(angles[i]);
      end
   endtask

   task automatic test_random_angles(input int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (ITEMS_PER_PHASE) begin
         send_angle(random_angle());
      end
   endtask

   task automatic test_pause_until_drained;
      sender_idle_pct = 0;
      repeat (10) begin
         send_angle(random_angle());
      end
      wait_for_results();
      repeat (10) begin
         send_angle(random_angle());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_angle_degrees = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_angles();
      test_random_angles(0);
      test_pause_until_drained();
      test_random_angles(65);
      test_random_angles(20);

      wait_for_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/tsc_pkg.sv
rtl/tsc_reduce.sv
rtl/tsc_cell.sv
rtl/tsc_round.sv
rtl/taylor_sine_cosine_top.sv
rtl/tsc_checker.sv
tb/taylor_sine_cosine_top_test.sv
